// ===== hw/rtl/lfg_pkg.sv =====
// ============================================================================
// lfg_pkg: shared constants and types of the lagged Fibonacci generator
// Word widths, lags, congruential constants, seeding phase lengths, the register index and the sequencer state type.
// ============================================================================
package lfg_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned OUT_W  = 31;

    // Lags of the recurrence x[k] = x[k-31] + x[k-3].
    localparam int unsigned LONG_LAG  = 31;
    localparam int unsigned SHORT_LAG = 3;

    // Multiplicative congruential seeding step.
    localparam int unsigned MULT_W = 15;
    localparam int unsigned PROD_W = WORD_W + MULT_W;
    localparam logic [MULT_W-1:0] MCG_MULT = 15'd16807;
    localparam logic [OUT_W-1:0]  MCG_MOD  = 31'h7FFF_FFFF;

    // Seeding phases: words 1 to 30, the copies 31 to 33, warm-up 34 to 343.
    localparam int unsigned COPY_START = 31;
    localparam int unsigned WARM_START = 34;
    localparam int unsigned WARM_END   = 344;
    localparam int unsigned MCG_WORDS  = COPY_START - 1;
    localparam int unsigned COPY_WORDS = WARM_START - COPY_START;
    localparam int unsigned WARM_WORDS = WARM_END - WARM_START;
    localparam int unsigned CNT_W      = $clog2(WARM_WORDS);

    // Configuration register index, taken from paddr[2].
    localparam logic REG_SEED = 1'b0;

    typedef enum logic [4:0] {
        ST_RUN  = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_RED  = 5'b00100,
        ST_COPY = 5'b01000,
        ST_WARM = 5'b10000
    } state_t;

endpackage

// ===== hw/rtl/lagged_fibonacci_random_generator.sv =====
// ============================================================================
// lagged_fibonacci_random_generator: additive lagged Fibonacci generator
// Lags 31 and 3, seeded from a register through a congruential step.
// ============================================================================
// Usage:
// Each word accepted on the input channel (in_valid high, in_stall low)
// asks for one 31-bit random number on the output channel. When restart is
// 1, or when the generator has not been seeded since reset, the block first
// reseeds from the seed register: the seed word, 30 congruential words
// (each a multiply state, then a reduce state), three copy words and 310
// warm-up sums, after which the result is produced. While seeding,
// in_stall stays high.
// Once seeded, a request without restart is answered in the next cycle,
// and one request per cycle is sustained while out_stall stays low: the
// only work is one 32-bit add of two taps of the 31-cell shift chain.
// The result sits in an output register; while out_valid and out_stall are
// both high that register holds, and a new request is taken only when the
// register will be free at the same edge.
// Reset clears the sequencer and the seeded flag and sets the seed register
// to 1; the history chain itself is not reset, since seeding always fills
// it before any number is drawn from it.
// The seed register sits at byte address 0 of the APB port; writes take
// effect at the next seeding.
// ============================================================================
module lagged_fibonacci_random_generator
(
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // Request channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         restart,
    // Result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [lfg_pkg::OUT_W-1:0]    random_value
);

    lfg_pkg::state_t state_reg, state_next;
    logic [lfg_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       seeded_reg, seeded_next;
    logic                       pending_reg, pending_next;
    logic                       out_valid_reg, out_valid_next;
    logic [lfg_pkg::OUT_W-1:0]  value_reg;
    logic [lfg_pkg::WORD_W-1:0] seed_reg;

    // cell_word[0] is the newest word, cell_word[30] the one 31 steps back.
    logic [lfg_pkg::WORD_W-1:0] cell_word [lfg_pkg::LONG_LAG];
    logic [lfg_pkg::WORD_W-1:0] shift_data;
    logic [lfg_pkg::WORD_W-1:0] lag_sum;
    logic [lfg_pkg::OUT_W-1:0]  mcg_word;
    logic                       shift;
    logic                       mcg_load;
    logic                       out_free;
    logic                       in_accept;
    logic                       need_seed;
    logic                       do_gen;
    logic                       cfg_write;

    // ------------------------------------------------------------------
    // Configuration: one seed register, read back on any read at index 0.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == lfg_pkg::REG_SEED);
    assign prdata    = (paddr[2] == lfg_pkg::REG_SEED) ? seed_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 32'd1;
        end
        else if (cfg_write)
        begin
            seed_reg <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // Handshake. A request is taken only while running with no seeding
    // result waiting, and when the output register frees at this edge.
    // ------------------------------------------------------------------
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == lfg_pkg::ST_RUN) && !pending_reg && out_free);
    assign in_accept = in_valid && !in_stall;
    assign need_seed = restart || !seeded_reg;
    assign do_gen    = (state_reg == lfg_pkg::ST_RUN) && out_free
                    && (pending_reg || (in_accept && !need_seed));

    assign lag_sum = cell_word[lfg_pkg::LONG_LAG-1] + cell_word[lfg_pkg::SHORT_LAG-1];

    // ------------------------------------------------------------------
    // Seeding sequencer and chain feed.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        seeded_next    = seeded_reg;
        pending_next   = pending_reg;
        shift          = 1'b0;
        shift_data     = lag_sum;
        mcg_load       = 1'b0;
        case (state_reg)
            lfg_pkg::ST_RUN:
            begin
                if (do_gen)
                begin
                    shift        = 1'b1;
                    pending_next = 1'b0;
                end
                else if (in_accept && need_seed)
                begin
                    // The seed becomes word 0 of the new history.
                    shift       = 1'b1;
                    shift_data  = seed_reg;
                    seeded_next = 1'b0;
                    cnt_next    = '0;
                    state_next  = lfg_pkg::ST_MUL;
                end
            end
            lfg_pkg::ST_MUL:
            begin
                mcg_load   = 1'b1;
                state_next = lfg_pkg::ST_RED;
            end
            lfg_pkg::ST_RED:
            begin
                shift      = 1'b1;
                shift_data = lfg_pkg::WORD_W'(mcg_word);
                if (cnt_reg == lfg_pkg::CNT_W'(lfg_pkg::MCG_WORDS - 1))
                begin
                    cnt_next   = '0;
                    state_next = lfg_pkg::ST_COPY;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = lfg_pkg::ST_MUL;
                end
            end
            lfg_pkg::ST_COPY:
            begin
                // Words 31 to 33 repeat words 0 to 2, the oldest cell.
                shift      = 1'b1;
                shift_data = cell_word[lfg_pkg::LONG_LAG-1];
                if (cnt_reg == lfg_pkg::CNT_W'(lfg_pkg::COPY_WORDS - 1))
                begin
                    cnt_next   = '0;
                    state_next = lfg_pkg::ST_WARM;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            lfg_pkg::ST_WARM:
            begin
                shift = 1'b1;
                if (cnt_reg == lfg_pkg::CNT_W'(lfg_pkg::WARM_WORDS - 1))
                begin
                    cnt_next     = '0;
                    seeded_next  = 1'b1;
                    pending_next = 1'b1;
                    state_next   = lfg_pkg::ST_RUN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = lfg_pkg::ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = do_gen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfg_pkg::ST_RUN;
            cnt_reg       <= '0;
            seeded_reg    <= 1'b0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            seeded_reg    <= seeded_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_gen)
        begin
            value_reg <= lag_sum[lfg_pkg::WORD_W-1:1];
        end
    end

    assign out_valid    = out_valid_reg;
    assign random_value = value_reg;

    // ------------------------------------------------------------------
    // History chain and seeding multiplier.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < lfg_pkg::LONG_LAG; i++)
    begin : g_cell
        lfg_cell u_cell
        (
            .clk      (clk),
            .shift    (shift),
            .word_in  ((i == 0) ? shift_data : cell_word[(i == 0) ? 0 : i - 1]),
            .word_out (cell_word[i])
        );
    end

    lfg_mcg u_mcg
    (
        .clk      (clk),
        .load     (mcg_load),
        .word_in  (cell_word[0]),
        .word_out (mcg_word)
    );

endmodule

// ===== hw/rtl/lfg_cell.sv =====
// ============================================================================
// lfg_cell: one history word of the generator chain
// Holds a word and takes its neighbor's word whenever the chain shifts.
// ============================================================================
module lfg_cell
(
    input  logic                        clk,
    input  logic                        shift,
    input  logic [lfg_pkg::WORD_W-1:0]  word_in,
    output logic [lfg_pkg::WORD_W-1:0]  word_out
);

    logic [lfg_pkg::WORD_W-1:0] word_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            word_reg <= word_in;
        end
    end

    assign word_out = word_reg;

endmodule

// ===== hw/rtl/lfg_mcg.sv =====
// ============================================================================
// lfg_mcg: congruential seeding step
// Multiplies the previous word by 16807 and reduces modulo 2^31-1.
// ============================================================================
module lfg_mcg
(
    input  logic                        clk,
    input  logic                        load,
    input  logic [lfg_pkg::WORD_W-1:0]  word_in,
    output logic [lfg_pkg::OUT_W-1:0]   word_out
);

    logic [lfg_pkg::WORD_W-1:0] fold;
    logic [lfg_pkg::PROD_W-1:0] prod_reg;
    logic [lfg_pkg::PROD_W-1:0] prod_next;
    logic [lfg_pkg::WORD_W-1:0] part_sum;
    logic [lfg_pkg::OUT_W-1:0]  reduced;

    // A negative seed is moved up by twice the modulus, which keeps the residue.
    assign fold      = word_in[lfg_pkg::WORD_W-1] ? (word_in - 32'd2) : word_in;
    assign prod_next = lfg_pkg::PROD_W'(fold) * lfg_pkg::PROD_W'(lfg_pkg::MCG_MULT);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    // 2^31 is one modulo 2^31-1, so the high part folds onto the low part.
    assign part_sum = {1'b0, prod_reg[lfg_pkg::OUT_W-1:0]}
                    + lfg_pkg::WORD_W'(prod_reg[lfg_pkg::PROD_W-1:lfg_pkg::OUT_W]);
    assign reduced  = part_sum[lfg_pkg::OUT_W-1:0]
                    + lfg_pkg::OUT_W'(part_sum[lfg_pkg::WORD_W-1]);
    assign word_out = (reduced == lfg_pkg::MCG_MOD) ? '0 : reduced;

endmodule

// ===== hw/rtl/lfg_checker.sv =====
// ============================================================================
// lfg_checker: port-level checks of the lagged Fibonacci generator
// Watches the handshakes and the seed register from the top-level ports.
// ============================================================================
module lfg_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [2:0]                 paddr,
    input logic [31:0]                pwdata,
    input logic [31:0]                prdata,
    input logic                       pready,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       restart,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [lfg_pkg::OUT_W-1:0]  random_value
);

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(random_value))
        else $error("result word changed while stalled");

    // A request either yields a result next cycle or starts seeding.
    a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid || in_stall)
        else $error("request neither answered nor seeding");

    // A restart request always holds off the next request while seeding.
    a_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && restart |=> in_stall)
        else $error("request taken during seeding");

    // The seed register reads back what was last written to it.
    a_seed_readback: assert property (@(posedge clk) disable iff (!rst_n)
        $past(psel && penable && pwrite && pready && !paddr[2]) && !paddr[2]
            |-> prdata == $past(pwdata))
        else $error("seed register readback mismatch");

endmodule

bind lagged_fibonacci_random_generator lfg_checker u_lfg_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .random_value (random_value)
);
